// ----- design/tree_lowest_common_ancestor_assert.svh -----
// assertion macros for the lowest common ancestor block
`ifndef TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH

// same-cycle implication
`define TLCA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tlca_pkg.sv -----
// shared types and constants for the lowest common ancestor block
package tlca_pkg;

	localparam int NODE_W    = 14;
	localparam int NODE_SPAN = 1 << NODE_W;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_EDGE  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_MARK,
		ST_SEARCH,
		ST_CLEAR
	} state_t;

	typedef enum logic [1:0] {
		RD_IN_A,
		RD_PAR,
		RD_B,
		RD_A
	} rd_sel_t;

	typedef struct packed {
		logic    edge_wr;
		logic    latch;
		rd_sel_t rd_sel;
		logic    mark_wr;
		logic    mark_val;
		logic    sweep_wr;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    hit_clr;
		logic    hit_set;
		logic    resp;
		logic    resp_miss;
	} cmd_t;

	typedef struct packed {
		logic in_ok;
		logic mark;
		logic has_par;
		logic step_last;
		logic sweep_last;
	} sts_t;

endpackage

// ----- design/tlca_dp.sv -----
// datapath: parent and mark memories, walk registers, counter and result registers
module tlca_dp #(
	parameter int MAX_NODES = 16384
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlca_pkg::cmd_t               cmd,
	output tlca_pkg::sts_t               sts,
	input  logic [tlca_pkg::NODE_W-1:0]  node_a,
	input  logic [tlca_pkg::NODE_W-1:0]  node_b,
	output logic                         done,
	output logic [tlca_pkg::NODE_W-1:0]  ancestor,
	output logic                         found
);

	localparam int DEPTH = (MAX_NODES < tlca_pkg::NODE_SPAN) ? MAX_NODES : tlca_pkg::NODE_SPAN;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_NODES);
	localparam int LIM_W = ((CW > tlca_pkg::NODE_W) ? CW : tlca_pkg::NODE_W) + 1;
	localparam logic [LIM_W-1:0] LIMIT      = LIM_W'(MAX_NODES);
	localparam logic [CW-1:0]    STEP_LAST  = CW'(MAX_NODES - 1);
	localparam logic [CW-1:0]    SWEEP_LAST = CW'(DEPTH - 1);

	// {has_parent, parent}
	logic [tlca_pkg::NODE_W:0] pmem [DEPTH];
	logic                      mmem [DEPTH];

	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             sweep_addr;
	logic [AW-1:0]             par_addr;
	logic [AW-1:0]             x_s1;
	logic [tlca_pkg::NODE_W:0] prd_s1;
	logic                      mrd_s1;
	logic                      byp_s1;
	logic                      byp_val_s1;
	logic [AW-1:0]             a_q;
	logic [AW-1:0]             b_q;
	logic [CW-1:0]             cnt_q;
	tlca_pkg::node_t           hit_q;
	logic                      hit_ok_q;
	logic                      done_q;
	tlca_pkg::node_t           ancestor_q;
	logic                      found_q;

	assign par_addr   = prd_s1[AW-1:0];
	assign sweep_addr = cnt_q[AW-1:0];

	always_comb begin
		case (cmd.rd_sel)
			tlca_pkg::RD_IN_A: rd_addr = node_a[AW-1:0];
			tlca_pkg::RD_PAR:  rd_addr = par_addr;
			tlca_pkg::RD_B:    rd_addr = b_q;
			tlca_pkg::RD_A:    rd_addr = a_q;
			default:           rd_addr = a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			pmem[sweep_addr] <= '0;
		end else if (cmd.edge_wr) begin
			pmem[node_b[AW-1:0]] <= {1'b1, node_a};
		end
		prd_s1 <= pmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			mmem[sweep_addr] <= 1'b0;
		end else if (cmd.mark_wr) begin
			mmem[x_s1] <= cmd.mark_val;
		end
		mrd_s1 <= mmem[rd_addr];
	end

	// write-through for a mark written to the address read in the same cycle
	always_ff @(posedge clk) begin
		x_s1       <= rd_addr;
		byp_s1     <= cmd.mark_wr && (x_s1 == rd_addr);
		byp_val_s1 <= cmd.mark_val;
		if (cmd.latch) begin
			a_q <= node_a[AW-1:0];
			b_q <= node_b[AW-1:0];
		end
		if (cmd.hit_set) begin
			hit_q <= tlca_pkg::NODE_W'(x_s1);
		end
		if (cmd.resp) begin
			ancestor_q <= hit_ok_q ? hit_q : '0;
		end else if (cmd.resp_miss) begin
			ancestor_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			hit_ok_q <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.hit_clr) begin
				hit_ok_q <= 1'b0;
			end else if (cmd.hit_set) begin
				hit_ok_q <= 1'b1;
			end
			done_q <= cmd.resp || cmd.resp_miss;
			if (cmd.resp) begin
				found_q <= hit_ok_q;
			end else if (cmd.resp_miss) begin
				found_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.in_ok      = (LIM_W'(node_a) < LIMIT) && (LIM_W'(node_b) < LIMIT);
		sts.mark       = byp_s1 ? byp_val_s1 : mrd_s1;
		sts.has_par    = prd_s1[tlca_pkg::NODE_W];
		sts.step_last  = (cnt_q == STEP_LAST);
		sts.sweep_last = (cnt_q == SWEEP_LAST);
	end

	assign done     = done_q;
	assign ancestor = ancestor_q;
	assign found    = found_q;

endmodule

// ----- design/tlca_ctrl.sv -----
// controller: sweep and three-phase chain walk state machine
module tlca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     func,
	input  tlca_pkg::sts_t sts,
	output tlca_pkg::cmd_t cmd,
	output logic           busy
);

	tlca_pkg::state_t state_q;
	tlca_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlca_pkg::ST_SWEEP;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = tlca_pkg::RD_IN_A;
		state_nx = state_q;
		busy     = 1'b1;
		case (state_q)
			tlca_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (func)
						tlca_pkg::FUNC_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_nx    = tlca_pkg::ST_SWEEP;
						end
						tlca_pkg::FUNC_EDGE: begin
							cmd.edge_wr = sts.in_ok;
						end
						tlca_pkg::FUNC_QUERY: begin
							if (sts.in_ok) begin
								cmd.latch   = 1'b1;
								cmd.hit_clr = 1'b1;
								state_nx    = tlca_pkg::ST_MARK;
							end else begin
								cmd.resp_miss = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tlca_pkg::ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.sweep_last) begin
					state_nx = tlca_pkg::ST_IDLE;
				end
			end
			tlca_pkg::ST_MARK: begin
				if (!sts.mark) begin
					cmd.mark_wr  = 1'b1;
					cmd.mark_val = 1'b1;
				end
				if (sts.mark || !sts.has_par) begin
					cmd.rd_sel  = tlca_pkg::RD_B;
					cmd.cnt_clr = 1'b1;
					state_nx    = tlca_pkg::ST_SEARCH;
				end else begin
					cmd.rd_sel = tlca_pkg::RD_PAR;
				end
			end
			tlca_pkg::ST_SEARCH: begin
				if (sts.mark) begin
					cmd.hit_set = 1'b1;
					cmd.rd_sel  = tlca_pkg::RD_A;
					state_nx    = tlca_pkg::ST_CLEAR;
				end else if (!sts.has_par || sts.step_last) begin
					cmd.rd_sel = tlca_pkg::RD_A;
					state_nx   = tlca_pkg::ST_CLEAR;
				end else begin
					cmd.cnt_inc = 1'b1;
					cmd.rd_sel  = tlca_pkg::RD_PAR;
				end
			end
			tlca_pkg::ST_CLEAR: begin
				if (!sts.mark) begin
					cmd.resp = 1'b1;
					state_nx = tlca_pkg::ST_IDLE;
				end else begin
					cmd.mark_wr  = 1'b1;
					cmd.mark_val = 1'b0;
					if (!sts.has_par) begin
						cmd.resp = 1'b1;
						state_nx = tlca_pkg::ST_IDLE;
					end else begin
						cmd.rd_sel = tlca_pkg::RD_PAR;
					end
				end
			end
			default: begin
				state_nx = tlca_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/tree_lowest_common_ancestor.sv -----
// lowest common ancestor over a parent table, top level
// edge item: busy stays low, the next item may follow at once
// query item: busy over the mark, search and unmark walks, one node visited per walk step
//   (one memory read per cycle), result strobe in the cycle after the last unmark step
// out-of-range query: result strobe in the cycle after acceptance, busy stays low
// clear item and reset: busy while a sweep clears min(MAX_NODES, 16384) table entries
module tree_lowest_common_ancestor #(
	parameter int MAX_NODES = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [tlca_pkg::NODE_W-1:0] node_a,
	input  logic [tlca_pkg::NODE_W-1:0] node_b,
	output logic                        done,
	output logic [tlca_pkg::NODE_W-1:0] ancestor,
	output logic                        found
);

	tlca_pkg::cmd_t cmd;
	tlca_pkg::sts_t sts;

	tlca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tlca_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.node_a   (node_a),
		.node_b   (node_b),
		.done     (done),
		.ancestor (ancestor),
		.found    (found)
	);

endmodule

// ----- design/tlca_chk.sv -----
// port-level checker for the lowest common ancestor block, with its bind
`include "tree_lowest_common_ancestor_assert.svh"

module tlca_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [1:0]                  func,
	input logic                        done,
	input logic [tlca_pkg::NODE_W-1:0] ancestor,
	input logic                        found
);

	logic take_edge;
	logic take_clear;

	assign take_edge  = start && !busy && (func == tlca_pkg::FUNC_EDGE);
	assign take_clear = start && !busy && (func == tlca_pkg::FUNC_CLEAR);

	`TLCA_ASSERT_NOW(a_miss_zero, clk, arst_n, done && !found, ancestor == '0, "miss with ancestor")
	`TLCA_ASSERT_NEXT(a_edge_free, clk, arst_n, take_edge, !busy, "edge item made block busy")
	`TLCA_ASSERT_NEXT(a_clear_busy, clk, arst_n, take_clear, busy, "clear item did not sweep")
	`TLCA_ASSERT_NEXT(a_no_stray, clk, arst_n, !busy && !start, !done, "result without item")

endmodule

bind tree_lowest_common_ancestor tlca_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.func     (func),
	.done     (done),
	.ancestor (ancestor),
	.found    (found)
);

// ----- test/testbench.sv -----
// testbench for the lowest common ancestor block against a parent-walk predictor
module testbench;

	localparam int                TREE_NODES   = 16384;
	localparam logic [1:0]        FUNC_UNUSED  = 2'd3;
	localparam tlca_pkg::node_t   TOP_NODE     = tlca_pkg::node_t'(tlca_pkg::NODE_SPAN - 1);
	localparam int                RANDOM_ITEMS = 1750;
	localparam int                TAIL_CYCLES  = 40;
	localparam int unsigned       CYCLE_LIMIT  = 4000000;

	typedef struct packed {
		tlca_pkg::node_t ancestor;
		logic            found;
	} lca_answer_t;

	class lca_book #(int TREE_NODES = 16384);
		tlca_pkg::node_t parent_of [tlca_pkg::NODE_SPAN];
		bit              has_par [tlca_pkg::NODE_SPAN];
		bit              on_path [tlca_pkg::NODE_SPAN];
		lca_answer_t     awaited [$];
		int              mismatches, queries, hits, edges, clears, ignored;

		function lca_answer_t common_ancestor(tlca_pkg::node_t a, tlca_pkg::node_t b);
			lca_answer_t     ans;
			tlca_pkg::node_t n;
			bit              walking;
			int              steps;
			ans.ancestor = '0;
			ans.found = 1'b0;
			if (a >= TREE_NODES || b >= TREE_NODES)
				return ans;
			// mark the first chain, stopping on a loop
			n = a;
			walking = 1'b1;
			while (walking) begin
				on_path[n] = 1'b1;
				if (!has_par[n])
					walking = 1'b0;
				else begin
					n = parent_of[n];
					if (on_path[n])
						walking = 1'b0;
				end
			end
			// climb the second chain to the first marked node
			n = b;
			walking = 1'b1;
			steps = 0;
			while (walking && steps < TREE_NODES) begin
				if (on_path[n]) begin
					ans.found = 1'b1;
					ans.ancestor = n;
					walking = 1'b0;
				end else if (!has_par[n])
					walking = 1'b0;
				else
					n = parent_of[n];
				steps++;
			end
			// unmark the first chain
			n = a;
			walking = 1'b1;
			while (walking && on_path[n]) begin
				on_path[n] = 1'b0;
				if (!has_par[n])
					walking = 1'b0;
				else
					n = parent_of[n];
			end
			return ans;
		endfunction

		function void note_item(logic [1:0] f, tlca_pkg::node_t a, tlca_pkg::node_t b);
			lca_answer_t ans;
			case (f)
				tlca_pkg::FUNC_CLEAR: begin
					foreach (has_par[i])
						has_par[i] = 1'b0;
					clears++;
				end
				tlca_pkg::FUNC_EDGE: begin
					if (a < TREE_NODES && b < TREE_NODES) begin
						parent_of[b] = a;
						has_par[b] = 1'b1;
					end
					edges++;
				end
				tlca_pkg::FUNC_QUERY: begin
					ans = common_ancestor(a, b);
					if (ans.found)
						hits++;
					queries++;
					awaited.insert(awaited.size(), ans);
				end
				default: ignored++;
			endcase
		endfunction

		function void check_result(tlca_pkg::node_t anc, logic fnd);
			lca_answer_t want;
			if (awaited.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected answer: ancestor %0d found %0d, no query pending",
						anc, fnd);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (anc !== want.ancestor || fnd !== want.found) begin
				if (mismatches < 10)
					$display("mismatch: want ancestor %0d found %0d, got %0d found %0d",
						want.ancestor, want.found, anc, fnd);
				mismatches++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [1:0]      func;
	tlca_pkg::node_t node_a;
	tlca_pkg::node_t node_b;
	logic            done;
	tlca_pkg::node_t ancestor;
	logic            found;

	lca_book #(TREE_NODES) book;
	tlca_pkg::node_t pool [64];
	int              pool_n;
	int              burst_left = 0;
	int unsigned     cycle_count = 0;

	tree_lowest_common_ancestor #(
		.MAX_NODES(TREE_NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.node_a(node_a),
		.node_b(node_b),
		.done(done),
		.ancestor(ancestor),
		.found(found)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_result(ancestor, found);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// bursts of random length separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
		end
		burst_left--;
	endtask

	task automatic issue(input logic [1:0] f, input tlca_pkg::node_t a,
		input tlca_pkg::node_t b);
		pace();
		start <= 1'b1;
		func <= f;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		book.note_item(f, a, b);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (book.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic tlca_pkg::node_t fresh_node(int upto);
		tlca_pkg::node_t cand;
		bit              clash;
		do begin
			cand = tlca_pkg::node_t'($urandom);
			clash = 1'b0;
			for (int k = 0; k < upto; k++)
				if (pool[k] == cand)
					clash = 1'b1;
		end while (clash);
		return cand;
	endfunction

	function automatic tlca_pkg::node_t any_node();
		if ($urandom_range(0, 7) == 0)
			return tlca_pkg::node_t'($urandom);
		return pool[$urandom_range(0, pool_n - 1)];
	endfunction

	initial begin
		int item_count;
		int phase_len;
		int pick;
		int child;
		int parent;
		int linked;
		book = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= tlca_pkg::FUNC_CLEAR;
		node_a <= '0;
		node_b <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, replacement, unused code, a loop, clear
		issue(tlca_pkg::FUNC_QUERY, '0, '0);
		issue(tlca_pkg::FUNC_QUERY, TOP_NODE, '0);
		issue(tlca_pkg::FUNC_EDGE, TOP_NODE, '0);
		issue(tlca_pkg::FUNC_EDGE, TOP_NODE, 14'd5);
		issue(tlca_pkg::FUNC_QUERY, '0, 14'd5);
		issue(tlca_pkg::FUNC_QUERY, '0, TOP_NODE);
		issue(tlca_pkg::FUNC_QUERY, TOP_NODE, '0);
		issue(tlca_pkg::FUNC_EDGE, 14'd5, '0);
		issue(tlca_pkg::FUNC_QUERY, '0, 14'd5);
		issue(tlca_pkg::FUNC_QUERY, 14'd5, TOP_NODE);
		issue(FUNC_UNUSED, 14'h2AAA, 14'h1555);
		issue(tlca_pkg::FUNC_EDGE, 14'h2AAA, 14'h1555);
		issue(tlca_pkg::FUNC_EDGE, 14'h1555, 14'h2AAA);
		issue(tlca_pkg::FUNC_QUERY, 14'h1555, 14'h2AAA);
		issue(tlca_pkg::FUNC_QUERY, '0, 14'h2AAA);
		drain();
		issue(tlca_pkg::FUNC_CLEAR, TOP_NODE, TOP_NODE);
		issue(tlca_pkg::FUNC_QUERY, '0, 14'd5);
		issue(tlca_pkg::FUNC_QUERY, 14'd5, 14'd5);
		issue(tlca_pkg::FUNC_EDGE, 14'd1, 14'd2);
		issue(tlca_pkg::FUNC_EDGE, 14'd2, 14'd3);
		issue(tlca_pkg::FUNC_QUERY, 14'd3, 14'd2);
		issue(tlca_pkg::FUNC_QUERY, 14'd2, 14'd3);
		issue(tlca_pkg::FUNC_QUERY, 14'd3, TOP_NODE);

		// random forests, each phase starting from a cleared tree
		item_count = 0;
		while (item_count < RANDOM_ITEMS) begin
			drain();
			issue(tlca_pkg::FUNC_CLEAR, tlca_pkg::node_t'($urandom),
				tlca_pkg::node_t'($urandom));
			item_count++;
			pool_n = $urandom_range(3, 40);
			for (int k = 0; k < pool_n; k++)
				pool[k] = fresh_node(k);
			linked = 1;
			phase_len = $urandom_range(60, 140);
			for (int s = 0; s < phase_len; s++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					if (linked < pool_n) begin
						child = linked;
						linked++;
						// leave some nodes as extra roots
						if ($urandom_range(0, 9) == 0)
							continue;
						parent = ($urandom_range(0, 2) == 0) ? child - 1 :
							$urandom_range(0, child - 1);
					end else begin
						child = $urandom_range(1, pool_n - 1);
						parent = $urandom_range(0, child - 1);
					end
					issue(tlca_pkg::FUNC_EDGE, pool[parent], pool[child]);
				end else if (pick < 88)
					issue(tlca_pkg::FUNC_QUERY, any_node(), any_node());
				else if (pick < 92) begin
					issue(FUNC_UNUSED, tlca_pkg::node_t'($urandom),
						tlca_pkg::node_t'($urandom));
					continue;
				end else
					issue(tlca_pkg::FUNC_EDGE, tlca_pkg::node_t'($urandom),
						tlca_pkg::node_t'($urandom));
				item_count++;
			end
			// close a loop through the root now and then
			if ($urandom_range(0, 3) == 0 && linked > 1) begin
				issue(tlca_pkg::FUNC_EDGE, pool[linked - 1], pool[0]);
				for (int k = 0; k < 6; k++)
					issue(tlca_pkg::FUNC_QUERY, pool[0], pool[$urandom_range(0, linked - 1)]);
				issue(tlca_pkg::FUNC_QUERY, fresh_node(pool_n), pool[0]);
				item_count += 8;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d queries (%0d with a common ancestor), %0d edge loads,",
			book.queries, book.hits, book.edges);
		$display("%0d tree clears and %0d unused codes; %0d mismatches",
			book.clears, book.ignored, book.mismatches);
		if (book.mismatches == 0 && book.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+design
design/tlca_pkg.sv
design/tlca_dp.sv
design/tlca_ctrl.sv
design/tree_lowest_common_ancestor.sv
design/tlca_chk.sv
test/testbench.sv
